[hdl/sbm_pkg.sv]
package sbm_pkg;

  localparam int MAX_SLOTS_DEF        = 4096;
  localparam int SECTORS_PER_PAGE_DEF = 8;

  localparam int WORD_BITS  = 32;
  localparam int GROUP_SIZE = 8;

  localparam int MODE_W     = 2;
  localparam int SLOT_IN_W  = 12;
  localparam int STATUS_W   = 3;
  localparam int COUNT_W    = 13;
  localparam int SECTOR_W   = 32;
  localparam int CFG_AW     = 4;
  localparam int CFG_DW     = 32;

  localparam logic [MODE_W-1:0] MODE_ALLOC    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RETRIEVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DISCARD  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_QUERY    = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INACTIVE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNUSED   = 3'd4;

  localparam logic [1:0] REG_START  = 2'd0;
  localparam logic [1:0] REG_LIMIT  = 2'd1;
  localparam logic [1:0] REG_ENABLE = 2'd2;

  // map word write-back seen by the summary flags
  typedef struct packed {
    logic wr;
    logic full;
  } sbm_upd_t;

endpackage

[hdl/sbm_ram.sv]
module sbm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/sbm_bit_scan.sv]
module sbm_bit_scan (
  input  logic [sbm_pkg::WORD_BITS-1:0] word_in,
  output logic                          zero_found,
  output logic [4:0]                    zero_idx
);

  logic [3:0]      byte_any;
  logic [3:0][2:0] byte_idx;

  // lowest clear bit: per-byte encoders, then pick the lowest byte
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      byte_any[b] = 1'b0;
      byte_idx[b] = 3'd0;
      for (int j = 7; j >= 0; j--) begin
        if (!word_in[b*8+j]) begin
          byte_any[b] = 1'b1;
          byte_idx[b] = 3'(j);
        end
      end
    end
    zero_found = 1'b0;
    zero_idx   = 5'd0;
    for (int b = 3; b >= 0; b--) begin
      if (byte_any[b]) begin
        zero_found = 1'b1;
        zero_idx   = {2'(b), byte_idx[b]};
      end
    end
  end

endmodule

[hdl/sbm_summary.sv]
module sbm_summary #(
  parameter int WORDS = 128,
  parameter int WORD_W = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  clr,
  input  sbm_pkg::sbm_upd_t     upd,
  input  logic [WORD_W-1:0]     upd_word,
  input  logic [WORD_W-1:0]     chk_word,
  output logic                  chk_valid,
  output logic                  free_found,
  output logic [WORD_W-1:0]     free_word
);

  localparam int GS     = sbm_pkg::GROUP_SIZE;
  localparam int NG     = (WORDS + GS - 1) / GS;
  localparam int IDX_W  = $clog2(GS);

  logic [WORDS-1:0]           valid_r, valid_nxt;
  logic [WORDS-1:0]           full_r, full_nxt;
  logic [NG-1:0]              grp_any_r, grp_any_nxt;
  logic [NG-1:0][IDX_W-1:0]   grp_idx_r, grp_idx_nxt;
  logic [NG*GS-1:0]           free_vec;

  always_comb begin
    valid_nxt = valid_r;
    full_nxt  = full_r;
    if (clr) begin
      valid_nxt = '0;
      full_nxt  = '0;
    end else if (upd.wr) begin
      valid_nxt[upd_word] = 1'b1;
      full_nxt[upd_word]  = upd.full;
    end
  end

  always_comb begin
    free_vec = '0;
    free_vec[WORDS-1:0] = ~full_r;
    for (int g = 0; g < NG; g++) begin
      grp_any_nxt[g] = 1'b0;
      grp_idx_nxt[g] = '0;
      for (int j = GS - 1; j >= 0; j--) begin
        if (free_vec[g*GS+j]) begin
          grp_any_nxt[g] = 1'b1;
          grp_idx_nxt[g] = IDX_W'(j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      full_r    <= '0;
      grp_any_r <= '0;
    end else begin
      valid_r   <= valid_nxt;
      full_r    <= full_nxt;
      grp_any_r <= grp_any_nxt;
    end
    grp_idx_r <= grp_idx_nxt;
  end

  always_comb begin
    free_found = 1'b0;
    free_word  = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        free_found = 1'b1;
        free_word  = WORD_W'(g * GS) + WORD_W'(grp_idx_r[g]);
      end
    end
  end

  assign chk_valid = valid_r[chk_word];

endmodule

[hdl/swap_slot_bitmap_allocator_top.sv]
// Swap slot allocator with a one-bit-per-slot used map held in a 32-bit-wide
// map RAM and a used count. One request is in flight at a time. Query,
// inactive, full-by-count and out-of-range requests go from accept straight to
// the result; retrieve and discard pass through map read, read-modify-write,
// sector add and result; allocate first picks the lowest word that is not
// full from per-word summary flags before the map read. The map RAM read is
// registered. A new request is taken while the previous result waits at the
// output. Reset and any write to a defined register clear the map and the
// count at once through per-word valid flags; there is no clearing pass.
module swap_slot_bitmap_allocator_top #(
  parameter int MAX_SLOTS        = sbm_pkg::MAX_SLOTS_DEF,
  parameter int SECTORS_PER_PAGE = sbm_pkg::SECTORS_PER_PAGE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [sbm_pkg::MODE_W-1:0]      in_mode,
  input  logic [sbm_pkg::SLOT_IN_W-1:0]   in_slot,

  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sbm_pkg::STATUS_W-1:0]    out_status,
  output logic [sbm_pkg::SLOT_IN_W-1:0]   out_granted_slot,
  output logic [sbm_pkg::SECTOR_W-1:0]    out_sector_address,
  output logic [sbm_pkg::COUNT_W-1:0]     out_used_count,

  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [sbm_pkg::CFG_AW-1:0]      cfg_paddr,
  input  logic [sbm_pkg::CFG_DW-1:0]      cfg_pwdata,
  output logic [sbm_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                            cfg_pready
);

  localparam int WB     = sbm_pkg::WORD_BITS;
  localparam int WORDS  = (MAX_SLOTS + WB - 1) / WB;
  localparam int WORD_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int SLOT_W = WORD_W + 5;
  localparam int CW     = sbm_pkg::COUNT_W;
  localparam int CMP_W  = (SLOT_W > CW) ? SLOT_W : CW;
  localparam int MAXC   = (MAX_SLOTS > (2**CW - 1)) ? (2**CW - 1) : MAX_SLOTS;
  localparam int SW     = sbm_pkg::SECTOR_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FIND = 3'd1;
  localparam logic [2:0] S_RMW  = 3'd2;
  localparam logic [2:0] S_SEC  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]                    state_r, state_nxt;
  logic [sbm_pkg::MODE_W-1:0]    mode_r, mode_nxt;
  logic [WORD_W-1:0]             word_r, word_nxt;
  logic [4:0]                    pos_r, pos_nxt;
  logic [sbm_pkg::STATUS_W-1:0]  status_r, status_nxt;
  logic [SLOT_W-1:0]             res_slot_r, res_slot_nxt;
  logic [SW-1:0]                 prod_r, prod_nxt;
  logic [SW-1:0]                 sector_r, sector_nxt;
  logic [CW-1:0]                 used_r, used_nxt;

  logic [SW-1:0]                 start_r, start_nxt;
  logic [CW-1:0]                 limit_r, limit_nxt;
  logic                          enable_r, enable_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [sbm_pkg::STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [sbm_pkg::SLOT_IN_W-1:0] out_slot_r, out_slot_nxt;
  logic [SW-1:0]                 out_sector_r, out_sector_nxt;
  logic [CW-1:0]                 out_count_r, out_count_nxt;

  logic                          cfg_wr, cfg_clr;
  logic [1:0]                    cfg_idx;
  logic [CW-1:0]                 total;
  logic                          in_acc;
  logic [SLOT_W-1:0]             in_slot_ext;

  logic [WORD_W-1:0]             rd_word;
  logic                          ram_we;
  logic [WB-1:0]                 ram_wdata, ram_rdata, map_word;
  sbm_pkg::sbm_upd_t             upd;
  logic                          chk_valid, free_found;
  logic [WORD_W-1:0]             free_word;
  logic                          zero_found;
  logic [4:0]                    zero_idx;
  logic [SLOT_W-1:0]             cand_slot;

  sbm_ram #(.WIDTH(WB), .DEPTH(WORDS)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (word_r),
    .wdata (ram_wdata),
    .raddr (rd_word),
    .rdata (ram_rdata)
  );

  sbm_summary #(.WORDS(WORDS), .WORD_W(WORD_W)) u_summary (
    .clk        (clk),
    .rst_n      (rst_n),
    .clr        (cfg_clr),
    .upd        (upd),
    .upd_word   (word_r),
    .chk_word   (word_r),
    .chk_valid  (chk_valid),
    .free_found (free_found),
    .free_word  (free_word)
  );

  assign map_word = chk_valid ? ram_rdata : '0;

  sbm_bit_scan u_scan (
    .word_in    (map_word),
    .zero_found (zero_found),
    .zero_idx   (zero_idx)
  );

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = cfg_paddr[3:2];

  always_comb begin
    start_nxt  = start_r;
    limit_nxt  = limit_r;
    enable_nxt = enable_r;
    cfg_clr    = 1'b0;
    if (cfg_wr) begin
      unique case (cfg_idx)
        sbm_pkg::REG_START: begin
          start_nxt = cfg_pwdata;
          cfg_clr   = 1'b1;
        end
        sbm_pkg::REG_LIMIT: begin
          limit_nxt = cfg_pwdata[CW-1:0];
          cfg_clr   = 1'b1;
        end
        sbm_pkg::REG_ENABLE: begin
          enable_nxt = cfg_pwdata[0];
          cfg_clr    = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      sbm_pkg::REG_START:  cfg_prdata = start_r;
      sbm_pkg::REG_LIMIT:  cfg_prdata = 32'(limit_r);
      sbm_pkg::REG_ENABLE: cfg_prdata = 32'(enable_r);
      default:             cfg_prdata = '0;
    endcase
  end

  assign total       = (limit_r > CW'(MAXC)) ? CW'(MAXC) : limit_r;
  assign in_ready    = (state_r == S_IDLE);
  assign in_acc      = in_valid & in_ready;
  assign in_slot_ext = SLOT_W'(in_slot);
  assign cand_slot   = {word_r, zero_idx};

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    word_nxt       = word_r;
    pos_nxt        = pos_r;
    status_nxt     = status_r;
    res_slot_nxt   = res_slot_r;
    prod_nxt       = prod_r;
    sector_nxt     = sector_r;
    used_nxt       = used_r;
    rd_word        = word_r;
    ram_we         = 1'b0;
    ram_wdata      = map_word;
    upd            = '0;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_sector_nxt = out_sector_r;
    out_count_nxt  = out_count_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          mode_nxt     = in_mode;
          res_slot_nxt = '0;
          sector_nxt   = '0;
          status_nxt   = sbm_pkg::ST_OK;
          word_nxt     = in_slot_ext[SLOT_W-1:5];
          pos_nxt      = in_slot_ext[4:0];
          rd_word      = in_slot_ext[SLOT_W-1:5];
          if (in_mode == sbm_pkg::MODE_QUERY) begin
            state_nxt = S_DONE;
          end else if (!enable_r) begin
            status_nxt = sbm_pkg::ST_INACTIVE;
            state_nxt  = S_DONE;
          end else if (in_mode == sbm_pkg::MODE_ALLOC) begin
            if (used_r >= total) begin
              status_nxt = sbm_pkg::ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_FIND;
            end
          end else if (CMP_W'(in_slot) >= CMP_W'(total)) begin
            status_nxt = sbm_pkg::ST_RANGE;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_RMW;
          end
        end
      end
      S_FIND: begin
        rd_word  = free_word;
        word_nxt = free_word;
        if (free_found) begin
          state_nxt = S_RMW;
        end else begin
          status_nxt = sbm_pkg::ST_FULL;
          state_nxt  = S_DONE;
        end
      end
      S_RMW: begin
        if (mode_r == sbm_pkg::MODE_ALLOC) begin
          if (!zero_found || (CMP_W'(cand_slot) >= CMP_W'(total))) begin
            status_nxt = sbm_pkg::ST_FULL;
            state_nxt  = S_DONE;
          end else begin
            ram_wdata          = map_word;
            ram_wdata[zero_idx] = 1'b1;
            ram_we             = 1'b1;
            upd.wr             = 1'b1;
            upd.full           = &ram_wdata;
            used_nxt           = used_r + 1'b1;
            res_slot_nxt       = cand_slot;
            prod_nxt           = SW'((SW'(cand_slot) + 1'b1) * SW'(SECTORS_PER_PAGE));
            state_nxt          = S_SEC;
          end
        end else begin
          if (!map_word[pos_r]) begin
            status_nxt = sbm_pkg::ST_UNUSED;
            state_nxt  = S_DONE;
          end else begin
            ram_wdata        = map_word;
            ram_wdata[pos_r] = 1'b0;
            ram_we           = 1'b1;
            upd.wr           = 1'b1;
            upd.full         = 1'b0;
            used_nxt         = used_r - 1'b1;
            res_slot_nxt     = {word_r, pos_r};
            prod_nxt         = SW'((SW'({word_r, pos_r}) + 1'b1) * SW'(SECTORS_PER_PAGE));
            state_nxt        = S_SEC;
          end
        end
      end
      S_SEC: begin
        sector_nxt = start_r + prod_r;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_slot_nxt   = sbm_pkg::SLOT_IN_W'(res_slot_r);
          out_sector_nxt = sector_r;
          out_count_nxt  = used_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_clr) begin
      used_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      start_r     <= '0;
      limit_r     <= '0;
      enable_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      start_r     <= start_nxt;
      limit_r     <= limit_nxt;
      enable_r    <= enable_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r       <= mode_nxt;
    word_r       <= word_nxt;
    pos_r        <= pos_nxt;
    status_r     <= status_nxt;
    res_slot_r   <= res_slot_nxt;
    prod_r       <= prod_nxt;
    sector_r     <= sector_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_sector_r <= out_sector_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_granted_slot   = out_slot_r;
  assign out_sector_address = out_sector_r;
  assign out_used_count     = out_count_r;

endmodule

[hdl/sbm_checker.sv]
module sbm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [sbm_pkg::STATUS_W-1:0]    out_status,
  input logic [sbm_pkg::SLOT_IN_W-1:0]   out_granted_slot,
  input logic [sbm_pkg::SECTOR_W-1:0]    out_sector_address,
  input logic [sbm_pkg::COUNT_W-1:0]     out_used_count,
  input logic                            cfg_psel,
  input logic                            cfg_pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_granted_slot) && $stable(out_sector_address) && $stable(out_used_count))
    else $error("result changed while stalled");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != sbm_pkg::ST_OK |->
      out_granted_slot == '0 && out_sector_address == '0)
    else $error("refused request carries a slot or sector");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == sbm_pkg::ST_OK || out_status == sbm_pkg::ST_INACTIVE ||
      out_status == sbm_pkg::ST_FULL || out_status == sbm_pkg::ST_RANGE ||
      out_status == sbm_pkg::ST_UNUSED)
    else $error("undefined status");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel |-> cfg_pready)
    else $error("register port stalled");

endmodule

bind swap_slot_bitmap_allocator_top sbm_checker u_sbm_checker (.*);
